[sv/nsec3_pkg.sv]
// ----------------------------------------------------------------------------
// nsec3_pkg
// Shared types, constants and helper functions for the NSEC3 hash core.
// ----------------------------------------------------------------------------
`default_nettype none

package nsec3_pkg;

    localparam int MAX_SALT_BYTES_DEF = 32;
    localparam int SALT_BYTES_STORED  = 32;
    localparam int DIGITS_OUT         = 32;
    localparam int ROUNDS             = 80;
    localparam int ADDR_W             = 6;

    localparam logic [7:0] ALG_SHA1 = 8'd1;

    localparam logic [2:0] REG_HASH_ALGORITHM  = 3'd0;
    localparam logic [2:0] REG_ITERATION_COUNT = 3'd1;
    localparam logic [2:0] REG_SALT_LENGTH     = 3'd2;
    localparam logic [2:0] REG_SALT_WORD_0     = 3'd3;
    localparam logic [2:0] REG_SALT_WORD_1     = 3'd4;
    localparam logic [2:0] REG_SALT_WORD_2     = 3'd5;
    localparam logic [2:0] REG_SALT_WORD_3     = 3'd6;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef struct packed {
        logic [7:0] name_byte;
        logic       last_byte;
    } in_data_t;

    typedef struct packed {
        logic [6:0] hash_char;
        logic       last_char;
        logic       bad_algorithm;
    } out_data_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SALT,
        ST_PAD,
        ST_ZERO,
        ST_LEN,
        ST_ROUND,
        ST_FOLD,
        ST_PASS_END,
        ST_DIGEST,
        ST_EMIT,
        ST_ERR
    } state_t;

    typedef enum logic [2:0] {
        SRC_NAME,
        SRC_SALT,
        SRC_PAD,
        SRC_ZERO,
        SRC_LEN,
        SRC_DIGEST
    } src_t;

    typedef struct packed {
        logic       wr;
        src_t       src;
        logic [5:0] cnt;
        logic       sha_start;
        logic       latch_len;
        logic       round_en;
        logic [6:0] round;
        logic       fold;
        logic       copy_digest;
        logic       load_char;
        logic       last_char;
        logic       load_err;
    } cmd_t;

    typedef struct packed {
        logic idx63;
        logic idx56;
        logic can_load;
    } status_t;

    function automatic logic [31:0] round_k(input logic [6:0] r);
        logic [31:0] k;
        if (r < 7'd20)
            k = 32'h5A827999;
        else if (r < 7'd40)
            k = 32'h6ED9EBA1;
        else if (r < 7'd60)
            k = 32'h8F1BBCDC;
        else
            k = 32'hCA62C1D6;
        return k;
    endfunction

    function automatic logic [6:0] b32_char(input logic [4:0] sym);
        logic [6:0] c;
        if (sym < 5'd10)
            c = 7'h30 + 7'(sym);
        else
            c = 7'd87 + 7'(sym);
        return c;
    endfunction

endpackage

`default_nettype wire

[sv/nsec3_ctrl.sv]
// ----------------------------------------------------------------------------
// nsec3_ctrl
// Sequencer: name intake, salt / padding / length feed, compression rounds,
// iteration passes and character emission.
// ----------------------------------------------------------------------------
`default_nettype none

module nsec3_ctrl #(
    parameter int MAX_SALT_BYTES = nsec3_pkg::MAX_SALT_BYTES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_last,
    output      logic               in_stall,
    input  wire logic [7:0]         hash_algorithm,
    input  wire logic [15:0]        iteration_count,
    input  wire logic [5:0]         salt_length,
    output      nsec3_pkg::cmd_t    cmd,
    input  wire nsec3_pkg::status_t sts
);

    nsec3_pkg::state_t state_reg, state_next, ret_reg, ret_next, after;
    logic [5:0]  cnt_reg, cnt_next;
    logic [15:0] pass_reg, pass_next;
    logic [6:0]  rnd_reg, rnd_next;
    logic [5:0]  nsalt;

    assign nsalt = (salt_length > 6'(MAX_SALT_BYTES)) ? 6'(MAX_SALT_BYTES) : salt_length;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nsec3_pkg::ST_IDLE;
            ret_reg   <= nsec3_pkg::ST_IDLE;
            cnt_reg   <= '0;
            pass_reg  <= '0;
            rnd_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            cnt_reg   <= cnt_next;
            pass_reg  <= pass_next;
            rnd_reg   <= rnd_next;
        end
    end

    always_comb
    begin
        after     = state_reg;
        ret_next  = ret_reg;
        cnt_next  = cnt_reg;
        pass_next = pass_reg;
        rnd_next  = rnd_reg;
        in_stall  = 1'b1;
        cmd       = '0;
        cmd.src   = nsec3_pkg::SRC_ZERO;
        cmd.cnt   = cnt_reg;
        cmd.round = rnd_reg;

        case (state_reg)
            nsec3_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.src  = nsec3_pkg::SRC_NAME;
                if (in_valid)
                begin
                    cmd.wr = 1'b1;
                    if (in_last)
                    begin
                        if (hash_algorithm != nsec3_pkg::ALG_SHA1)
                            after = nsec3_pkg::ST_ERR;
                        else
                        begin
                            after     = nsec3_pkg::ST_SALT;
                            cnt_next  = '0;
                            pass_next = '0;
                        end
                    end
                end
            end
            nsec3_pkg::ST_SALT:
            begin
                cmd.src = nsec3_pkg::SRC_SALT;
                if (cnt_reg < nsalt)
                begin
                    cmd.wr   = 1'b1;
                    cnt_next = cnt_reg + 6'd1;
                end
                else
                begin
                    cmd.latch_len = 1'b1;
                    cnt_next      = '0;
                    after         = nsec3_pkg::ST_PAD;
                end
            end
            nsec3_pkg::ST_PAD:
            begin
                cmd.src = nsec3_pkg::SRC_PAD;
                cmd.wr  = 1'b1;
                after   = nsec3_pkg::ST_ZERO;
            end
            nsec3_pkg::ST_ZERO:
            begin
                if (!sts.idx56)
                    cmd.wr = 1'b1;
                else
                    after = nsec3_pkg::ST_LEN;
            end
            nsec3_pkg::ST_LEN:
            begin
                cmd.src  = nsec3_pkg::SRC_LEN;
                cmd.wr   = 1'b1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd7)
                begin
                    cnt_next = '0;
                    after    = nsec3_pkg::ST_PASS_END;
                end
            end
            nsec3_pkg::ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                rnd_next     = rnd_reg + 7'd1;
                if (rnd_reg == 7'(nsec3_pkg::ROUNDS - 1))
                begin
                    rnd_next = '0;
                    after    = nsec3_pkg::ST_FOLD;
                end
            end
            nsec3_pkg::ST_FOLD:
            begin
                cmd.fold = 1'b1;
                after    = ret_reg;
            end
            nsec3_pkg::ST_PASS_END:
            begin
                cmd.copy_digest = 1'b1;
                cmd.sha_start   = 1'b1;
                cnt_next        = '0;
                if (pass_reg < iteration_count)
                begin
                    pass_next = pass_reg + 16'd1;
                    after     = nsec3_pkg::ST_DIGEST;
                end
                else
                    after = nsec3_pkg::ST_EMIT;
            end
            nsec3_pkg::ST_DIGEST:
            begin
                cmd.src  = nsec3_pkg::SRC_DIGEST;
                cmd.wr   = 1'b1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd19)
                begin
                    cnt_next = '0;
                    after    = nsec3_pkg::ST_SALT;
                end
            end
            nsec3_pkg::ST_EMIT:
            begin
                if (sts.can_load)
                begin
                    cmd.load_char = 1'b1;
                    cmd.last_char = (cnt_reg == 6'(nsec3_pkg::DIGITS_OUT - 1));
                    cnt_next      = cnt_reg + 6'd1;
                    if (cmd.last_char)
                    begin
                        cnt_next = '0;
                        after    = nsec3_pkg::ST_IDLE;
                    end
                end
            end
            nsec3_pkg::ST_ERR:
            begin
                if (sts.can_load)
                begin
                    cmd.load_err  = 1'b1;
                    cmd.sha_start = 1'b1;
                    after         = nsec3_pkg::ST_IDLE;
                end
            end
            default:
            begin
                after = nsec3_pkg::ST_IDLE;
            end
        endcase

        // a byte landing in the last slot of the block kicks off compression
        if (cmd.wr && sts.idx63 && after != nsec3_pkg::ST_ERR)
        begin
            state_next = nsec3_pkg::ST_ROUND;
            ret_next   = after;
        end
        else
            state_next = after;
    end

`ifndef ASSERT_OFF
    a_rnd_only_in_round: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != nsec3_pkg::ST_ROUND) |-> (rnd_reg == 7'd0))
        else $error("round counter active outside compression");

    a_round_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != nsec3_pkg::ST_ROUND) ##1 (state_reg == nsec3_pkg::ST_ROUND)
        |-> $past(cmd.wr && sts.idx63))
        else $error("compression started without a full block");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nsec3_pkg::ST_LEN) |-> (cnt_reg < 6'd8))
        else $error("length field overrun");

    a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nsec3_pkg::ST_DIGEST) |-> (pass_reg != 16'd0))
        else $error("digest feed without an iteration pass");
`endif

endmodule

`default_nettype wire

[sv/nsec3_dp.sv]
// ----------------------------------------------------------------------------
// nsec3_dp
// SHA-1 datapath: block buffer with rolling schedule, round unit, chaining
// value, digest holding register and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module nsec3_dp (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire nsec3_pkg::cmd_t      cmd,
    output      nsec3_pkg::status_t   sts,
    input  wire logic [7:0]           in_byte,
    input  wire logic [255:0]         salt_all,
    output      logic                 out_valid,
    input  wire logic                 out_stall,
    output      nsec3_pkg::out_data_t out_data
);

    logic [31:0]  w_reg [16];
    logic [31:0]  w_next [16];
    logic [31:0]  chain_reg [5];
    logic [31:0]  chain_next [5];
    logic [31:0]  vars_reg [5];
    logic [31:0]  vars_next [5];
    logic [60:0]  count_reg, count_next;
    logic [63:0]  len_reg, len_next;
    logic [159:0] digest_reg, digest_next;
    nsec3_pkg::out_data_t out_reg, out_next;
    logic         out_valid_reg, out_valid_next;

    logic [7:0]   byte_val;
    logic [31:0]  wt, f, t;
    logic [3:0]   widx;
    logic [1:0]   lane;

    assign widx = count_reg[5:2];
    assign lane = count_reg[1:0];

    assign sts.idx63    = (count_reg[5:0] == 6'd63);
    assign sts.idx56    = (count_reg[5:0] == 6'd56);
    assign sts.can_load = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        case (cmd.src)
            nsec3_pkg::SRC_NAME:   byte_val = in_byte;
            nsec3_pkg::SRC_SALT:   byte_val = (cmd.cnt < 6'(nsec3_pkg::SALT_BYTES_STORED))
                                            ? salt_all[{~cmd.cnt[4:0], 3'b000} +: 8] : 8'h00;
            nsec3_pkg::SRC_PAD:    byte_val = nsec3_pkg::PAD_BYTE;
            nsec3_pkg::SRC_LEN:    byte_val = len_reg[63:56];
            nsec3_pkg::SRC_DIGEST: byte_val = digest_reg[159:152];
            default:               byte_val = 8'h00;
        endcase
    end

    // round function
    always_comb
    begin
        if (cmd.round < 7'd16)
            wt = w_reg[0];
        else
        begin
            wt = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
            wt = {wt[30:0], wt[31]};
        end
        if (cmd.round < 7'd20)
            f = (vars_reg[1] & vars_reg[2]) | (~vars_reg[1] & vars_reg[3]);
        else if (cmd.round < 7'd40)
            f = vars_reg[1] ^ vars_reg[2] ^ vars_reg[3];
        else if (cmd.round < 7'd60)
            f = (vars_reg[1] & vars_reg[2]) | (vars_reg[1] & vars_reg[3])
              | (vars_reg[2] & vars_reg[3]);
        else
            f = vars_reg[1] ^ vars_reg[2] ^ vars_reg[3];
        t = {vars_reg[0][26:0], vars_reg[0][31:27]} + f + vars_reg[4]
          + nsec3_pkg::round_k(cmd.round) + wt;
    end

    always_comb
    begin
        w_next      = w_reg;
        chain_next  = chain_reg;
        vars_next   = vars_reg;
        count_next  = count_reg;
        len_next    = len_reg;
        digest_next = digest_reg;
        out_next    = out_reg;

        if (cmd.wr)
        begin
            w_next[widx][{~lane, 3'b000} +: 8] = byte_val;
            count_next = count_reg + 61'd1;
            if (sts.idx63)
                vars_next = chain_reg;
            if (cmd.src == nsec3_pkg::SRC_LEN)
                len_next = {len_reg[55:0], 8'h00};
            if (cmd.src == nsec3_pkg::SRC_DIGEST)
                digest_next = {digest_reg[151:0], 8'h00};
        end

        if (cmd.latch_len)
            len_next = {count_reg, 3'b000};

        if (cmd.round_en)
        begin
            for (int i = 0; i < 15; i++)
                w_next[i] = w_reg[i + 1];
            w_next[15]   = wt;
            vars_next[4] = vars_reg[3];
            vars_next[3] = vars_reg[2];
            vars_next[2] = {vars_reg[1][1:0], vars_reg[1][31:2]};
            vars_next[1] = vars_reg[0];
            vars_next[0] = t;
        end

        if (cmd.fold)
            for (int i = 0; i < 5; i++)
                chain_next[i] = chain_reg[i] + vars_reg[i];

        if (cmd.copy_digest)
            digest_next = {chain_reg[0], chain_reg[1], chain_reg[2], chain_reg[3], chain_reg[4]};

        if (cmd.sha_start)
        begin
            chain_next[0] = nsec3_pkg::IV0;
            chain_next[1] = nsec3_pkg::IV1;
            chain_next[2] = nsec3_pkg::IV2;
            chain_next[3] = nsec3_pkg::IV3;
            chain_next[4] = nsec3_pkg::IV4;
            count_next    = '0;
        end

        if (cmd.load_char)
        begin
            out_next.hash_char     = nsec3_pkg::b32_char(digest_reg[159:155]);
            out_next.last_char     = cmd.last_char;
            out_next.bad_algorithm = 1'b0;
            digest_next            = {digest_reg[154:0], 5'b00000};
        end
        else if (cmd.load_err)
        begin
            out_next.hash_char     = 7'd0;
            out_next.last_char     = 1'b1;
            out_next.bad_algorithm = 1'b1;
        end

        if (cmd.load_char || cmd.load_err)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        w_reg      <= w_next;
        vars_reg   <= vars_next;
        len_reg    <= len_next;
        digest_reg <= digest_next;
        out_reg    <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg[0]  <= nsec3_pkg::IV0;
            chain_reg[1]  <= nsec3_pkg::IV1;
            chain_reg[2]  <= nsec3_pkg::IV2;
            chain_reg[3]  <= nsec3_pkg::IV3;
            chain_reg[4]  <= nsec3_pkg::IV4;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            chain_reg     <= chain_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

[sv/nsec3_iterated_sha1_hash_core.sv]
// ----------------------------------------------------------------------------
// nsec3_iterated_sha1_hash_core
// NSEC3 owner-name hash: iterated SHA-1 over name || salt, base32hex output.
// ----------------------------------------------------------------------------
// Name bytes are absorbed while the core is idle; input stalls while each filled
// 64-byte block is compressed in 80 rounds on the single shared round unit plus
// the fold (the round registers load in the cycle that writes the last byte).
// On the final byte the block appends the salt, padding and length, then runs
// iteration_count more passes over the digest, salt, padding and length, each
// block of which is compressed as above. The 32 characters
// then leave at one per cycle when the sink does not stall; the next name is
// accepted once the last character sits in the output register. Configure
// only while idle. Registers are 64-bit APB words at byte address 8*index.
// ----------------------------------------------------------------------------
`default_nettype none

module nsec3_iterated_sha1_hash_core #(
    parameter int MAX_SALT_BYTES = nsec3_pkg::MAX_SALT_BYTES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output      logic                        in_stall,
    input  wire nsec3_pkg::in_data_t         in_data,
    output      logic                        out_valid,
    input  wire logic                        out_stall,
    output      nsec3_pkg::out_data_t        out_data,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [nsec3_pkg::ADDR_W-1:0] paddr,
    input  wire logic [63:0]                 pwdata,
    output      logic [63:0]                 prdata,
    output      logic                        pready
);

    logic [7:0]  alg_reg;
    logic [15:0] iter_reg;
    logic [5:0]  slen_reg;
    logic [63:0] salt0_reg, salt1_reg, salt2_reg, salt3_reg;
    logic [2:0]  reg_idx;
    logic        wr_en;

    nsec3_pkg::cmd_t    cmd;
    nsec3_pkg::status_t sts;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alg_reg   <= nsec3_pkg::ALG_SHA1;
            iter_reg  <= '0;
            slen_reg  <= '0;
            salt0_reg <= '0;
            salt1_reg <= '0;
            salt2_reg <= '0;
            salt3_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                nsec3_pkg::REG_HASH_ALGORITHM:  alg_reg   <= pwdata[7:0];
                nsec3_pkg::REG_ITERATION_COUNT: iter_reg  <= pwdata[15:0];
                nsec3_pkg::REG_SALT_LENGTH:     slen_reg  <= pwdata[5:0];
                nsec3_pkg::REG_SALT_WORD_0:     salt0_reg <= pwdata;
                nsec3_pkg::REG_SALT_WORD_1:     salt1_reg <= pwdata;
                nsec3_pkg::REG_SALT_WORD_2:     salt2_reg <= pwdata;
                nsec3_pkg::REG_SALT_WORD_3:     salt3_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            nsec3_pkg::REG_HASH_ALGORITHM:  prdata = {56'd0, alg_reg};
            nsec3_pkg::REG_ITERATION_COUNT: prdata = {48'd0, iter_reg};
            nsec3_pkg::REG_SALT_LENGTH:     prdata = {58'd0, slen_reg};
            nsec3_pkg::REG_SALT_WORD_0:     prdata = salt0_reg;
            nsec3_pkg::REG_SALT_WORD_1:     prdata = salt1_reg;
            nsec3_pkg::REG_SALT_WORD_2:     prdata = salt2_reg;
            nsec3_pkg::REG_SALT_WORD_3:     prdata = salt3_reg;
            default:                        prdata = '0;
        endcase
    end

    nsec3_ctrl #(
        .MAX_SALT_BYTES(MAX_SALT_BYTES)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_last         (in_data.last_byte),
        .in_stall        (in_stall),
        .hash_algorithm  (alg_reg),
        .iteration_count (iter_reg),
        .salt_length     (slen_reg),
        .cmd             (cmd),
        .sts             (sts)
    );

    nsec3_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_byte   (in_data.name_byte),
        .salt_all  ({salt0_reg, salt1_reg, salt2_reg, salt3_reg}),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

[tb/sv/nsec3_iterated_sha1_hash_core_tb.sv]
// ----------------------------------------------------------------------------
// nsec3_iterated_sha1_hash_core_tb
// Self-checking bench for the NSEC3 iterated SHA-1 hash core.
// ----------------------------------------------------------------------------
// Streams owner names byte by byte and programs the core over APB between
// names. A behavioral SHA-1 and base32hex encoder predicts every character.
// Each output transaction is checked against the oldest prediction. Random
// source gaps and sink stalls are applied, except while quiet is set.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module nsec3_iterated_sha1_hash_core_tb;

    localparam int WATCHDOG_CYCLES = 200000;
    localparam int IDLE_PCT        = 27;
    localparam int SETTLE_CYCLES   = 300;
    localparam int RANDOM_BYTES    = 400;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    nsec3_pkg::in_data_t in_data;
    logic out_valid;
    logic out_stall;
    nsec3_pkg::out_data_t out_data;
    logic psel;
    logic penable;
    logic pwrite;
    logic [nsec3_pkg::ADDR_W-1:0] paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic pready;

    nsec3_iterated_sha1_hash_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // shadow copy of the register file
    logic [7:0]  cfg_alg;
    logic [15:0] cfg_iters;
    logic [5:0]  cfg_salt_len;
    logic [63:0] cfg_salt [4];

    logic [7:0] name_bytes [$];
    nsec3_pkg::out_data_t expected_chars [$];

    int  errors;
    int  bytes_sent;
    int  chars_checked;
    int  names_hashed;
    int  names_rejected;
    bit  quiet;        // no gaps, no stalls
    int  idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor
    function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [159:0] sha1_of(input logic [7:0] msg [$]);
        logic [31:0] h [5];
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        logic [63:0] bitlen;
        int blk;
        int j;
        bitlen = 64'(msg.size()) << 3;
        msg.push_back(8'h80);
        while (msg.size() % 64 != 56)
            msg.push_back(8'h00);
        for (j = 7; j >= 0; j--)
            msg.push_back(bitlen[8*j +: 8]);
        h[0] = 32'h67452301; h[1] = 32'hEFCDAB89; h[2] = 32'h98BADCFE;
        h[3] = 32'h10325476; h[4] = 32'hC3D2E1F0;
        for (blk = 0; blk < msg.size(); blk += 64)
        begin
            for (j = 0; j < 16; j++)
                w[j] = {msg[blk+4*j], msg[blk+4*j+1], msg[blk+4*j+2], msg[blk+4*j+3]};
            for (j = 16; j < 80; j++)
                w[j] = rol32(w[j-3] ^ w[j-8] ^ w[j-14] ^ w[j-16], 1);
            a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
            for (j = 0; j < 80; j++)
            begin
                if (j < 20)
                begin
                    f = (b & c) | (~b & d);
                    k = 32'h5A827999;
                end
                else if (j < 40)
                begin
                    f = b ^ c ^ d;
                    k = 32'h6ED9EBA1;
                end
                else if (j < 60)
                begin
                    f = (b & c) | (b & d) | (c & d);
                    k = 32'h8F1BBCDC;
                end
                else
                begin
                    f = b ^ c ^ d;
                    k = 32'hCA62C1D6;
                end
                t = rol32(a, 5) + f + e + k + w[j];
                e = d; d = c; c = rol32(b, 30); b = a; a = t;
            end
            h[0] += a; h[1] += b; h[2] += c; h[3] += d; h[4] += e;
        end
        return {h[0], h[1], h[2], h[3], h[4]};
    endfunction

    // absorb one name byte; on the last byte queue the expected characters
    task automatic predict_name_byte(input logic [7:0] nb, input logic last);
        logic [7:0] msg [$];
        logic [159:0] digest;
        logic [4:0] sym;
        nsec3_pkg::out_data_t oc;
        int salt_n;
        int i;
        name_bytes.push_back(nb);
        if (!last)
            return;
        if (cfg_alg != nsec3_pkg::ALG_SHA1)
        begin
            oc.hash_char = '0;
            oc.last_char = 1'b1;
            oc.bad_algorithm = 1'b1;
            expected_chars.push_back(oc);
            name_bytes.delete();
            names_rejected++;
            return;
        end
        salt_n = (cfg_salt_len > 32) ? 32 : cfg_salt_len;
        msg = name_bytes;
        for (i = 0; i < salt_n; i++)
            msg.push_back(cfg_salt[i/8][63 - 8*(i%8) -: 8]);
        digest = sha1_of(msg);
        for (int p = 0; p < cfg_iters; p++)
        begin
            msg.delete();
            for (i = 0; i < 20; i++)
                msg.push_back(digest[159 - 8*i -: 8]);
            for (i = 0; i < salt_n; i++)
                msg.push_back(cfg_salt[i/8][63 - 8*(i%8) -: 8]);
            digest = sha1_of(msg);
        end
        for (i = 0; i < 32; i++)
        begin
            sym = digest[159 - 5*i -: 5];
            oc.hash_char = (sym < 10) ? 7'(8'd48 + sym) : 7'(8'd87 + sym);
            oc.last_char = (i == 31);
            oc.bad_algorithm = 1'b0;
            expected_chars.push_back(oc);
        end
        name_bytes.delete();
        names_hashed++;
    endtask

    // ---------------------------------------------------------------- checker
    logic in_fire, out_fire;

    // handshake inputs change only at posedge, so negedge sampling is stable
    always @(negedge clk)
    begin
        in_fire  <= rst_n && in_valid && !in_stall;
        out_fire <= rst_n && out_valid && !out_stall;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_chars.size() == 0)
            begin
                $display("%0t: unexpected transaction, expected none, actual %p",
                         $time, out_data);
                errors++;
            end
            else
            begin
                nsec3_pkg::out_data_t ex;
                ex = expected_chars.pop_front();
                chars_checked++;
                if (out_data.hash_char !== ex.hash_char)
                begin
                    $display("%0t: hash_char mismatch, expected %h, actual %h",
                             $time, ex.hash_char, out_data.hash_char);
                    errors++;
                end
                if (out_data.last_char !== ex.last_char)
                begin
                    $display("%0t: last_char mismatch, expected %b, actual %b",
                             $time, ex.last_char, out_data.last_char);
                    errors++;
                end
                if (out_data.bad_algorithm !== ex.bad_algorithm)
                begin
                    $display("%0t: bad_algorithm mismatch, expected %b, actual %b",
                             $time, ex.bad_algorithm, out_data.bad_algorithm);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
        if (in_fire || out_fire)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_CYCLES)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------- drivers
    task automatic send_name_byte(input logic [7:0] nb, input logic last);
        bit stalled;
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data.name_byte <= nb;
        in_data.last_byte <= last;
        do
        begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end
        while (stalled);
        bytes_sent++;
        predict_name_byte(nb, last);
    endtask

    task automatic send_name(input logic [7:0] nm [$]);
        foreach (nm[i])
            send_name_byte(nm[i], i == nm.size() - 1);
    endtask

    task automatic send_random_name(input int len);
        logic [7:0] nm [$];
        repeat (len) nm.push_back(8'($urandom));
        send_name(nm);
    endtask

    // lower valid and wait for the core to go idle
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= nsec3_pkg::ADDR_W'(idx) << 3;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            nsec3_pkg::REG_HASH_ALGORITHM:  cfg_alg = val[7:0];
            nsec3_pkg::REG_ITERATION_COUNT: cfg_iters = val[15:0];
            nsec3_pkg::REG_SALT_LENGTH:     cfg_salt_len = val[5:0];
            nsec3_pkg::REG_SALT_WORD_0:     cfg_salt[0] = val;
            nsec3_pkg::REG_SALT_WORD_1:     cfg_salt[1] = val;
            nsec3_pkg::REG_SALT_WORD_2:     cfg_salt[2] = val;
            nsec3_pkg::REG_SALT_WORD_3:     cfg_salt[3] = val;
            default: ;
        endcase
    endtask

    task automatic program_core(input logic [7:0] alg, input logic [15:0] iters,
                                input logic [5:0] slen);
        apb_write(nsec3_pkg::REG_HASH_ALGORITHM, 64'(alg));
        apb_write(nsec3_pkg::REG_ITERATION_COUNT, 64'(iters));
        apb_write(nsec3_pkg::REG_SALT_LENGTH, 64'(slen));
        apb_write(nsec3_pkg::REG_SALT_WORD_0, {$urandom, $urandom});
        apb_write(nsec3_pkg::REG_SALT_WORD_1, {$urandom, $urandom});
        apb_write(nsec3_pkg::REG_SALT_WORD_2, {$urandom, $urandom});
        apb_write(nsec3_pkg::REG_SALT_WORD_3, {$urandom, $urandom});
    endtask

    // ---------------------------------------------------------------- tests
    // reset defaults: SHA-1, no salt, no extra passes
    task automatic test_defaults();
        send_name('{8'h00});
        send_name('{8'hFF});
        send_name('{8'h03, "w", "w", "w", 8'h00});
        send_name('{8'hAA, 8'h55});
        drain();
    endtask

    // rejected algorithm numbers; max iteration count is safe on this path
    task automatic test_bad_algorithm();
        program_core(8'd0, 16'hFFFF, 6'd32);
        send_name('{8'h01, 8'h7F});
        drain();
        apb_write(nsec3_pkg::REG_HASH_ALGORITHM, 64'd255);
        send_name('{8'h80});
        drain();
    endtask

    // full salt, a length above the cap that saturates, and a short all-ones salt
    task automatic test_salt_extremes();
        program_core(nsec3_pkg::ALG_SHA1, 16'd1, 6'd32);
        send_name('{8'h07, "e", "x", "a"});
        drain();
        program_core(nsec3_pkg::ALG_SHA1, 16'd0, 6'd63);
        send_name('{8'h5A});
        drain();
        apb_write(nsec3_pkg::REG_SALT_WORD_0, 64'hFFFF_FFFF_FFFF_FFFF);
        apb_write(nsec3_pkg::REG_SALT_LENGTH, 64'd8);
        send_name('{8'h00, 8'hFF});
        drain();
    endtask

    task automatic test_random_names();
        int start;
        int len;
        int sel;
        int grp;
        start = bytes_sent;
        grp = 0;
        while (bytes_sent - start < RANDOM_BYTES)
        begin
            sel = $urandom_range(99);
            // one group always runs without gaps or stalls
            quiet = (grp == 1) || ($urandom_range(5) == 0);
            program_core((sel < 10) ? 8'($urandom_range(2, 255)) : nsec3_pkg::ALG_SHA1,
                         (sel > 85) ? 16'($urandom_range(20, 40))
                                    : 16'($urandom_range(0, 6)),
                         6'($urandom_range(0, 63)));
            repeat ($urandom_range(2, 5))
            begin
                sel = $urandom_range(99);
                if (sel < 70)
                    len = $urandom_range(1, 20);
                else if (sel < 95)
                    len = $urandom_range(50, 70);
                else
                    len = $urandom_range(118, 130);
                if (bytes_sent - start < RANDOM_BYTES)
                    send_random_name(len);
            end
            drain();
            grp++;
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        errors = 0;
        bytes_sent = 0;
        chars_checked = 0;
        names_hashed = 0;
        names_rejected = 0;
        quiet = 1'b0;
        idle_cycles = 0;
        cfg_alg = nsec3_pkg::ALG_SHA1;
        cfg_iters = '0;
        cfg_salt_len = '0;
        foreach (cfg_salt[i])
            cfg_salt[i] = '0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults();
        test_bad_algorithm();
        test_salt_extremes();
        test_random_names();

        $display("Covered %0d name bytes: %0d names hashed, %0d rejected, %0d chars checked",
                 bytes_sent, names_hashed, names_rejected, chars_checked);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
